@@ hw/rtl/radio_frame_build_checksum_defines.svh @@
// Assertion macros used by the checker file.
`ifndef RADIO_FRAME_BUILD_CHECKSUM_DEFINES_SVH
`define RADIO_FRAME_BUILD_CHECKSUM_DEFINES_SVH

// same-cycle implication, checked on every clock edge out of reset
`define RFBC_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rfbc check failed");

// next-cycle implication
`define RFBC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rfbc check failed");

`endif

@@ hw/rtl/rfbc_pkg.sv @@
package rfbc_pkg;

  localparam int unsigned ADDRESS_BYTES_DEF = 4;
  localparam int unsigned MAX_VALUE_LEN_DEF = 32;

  typedef struct packed {
    logic [31:0] dest_address;
    logic [7:0]  function_code;
    logic [7:0]  register_id;
    logic        is_integer;
    logic        has_byte;
    logic [7:0]  value_byte;
    logic        value_last;
  } in_t;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       frame_last;
  } out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_HDR,
    ST_RD,
    ST_VAL,
    ST_SUM
  } state_t;

  typedef struct packed {
    logic out_hdr;  // emit top byte of header shifter
    logic out_val;  // emit buffer read data
    logic out_sum;  // emit checksum, close frame
    logic rd_en;    // read value buffer
  } seq_ctrl_t;

endpackage

@@ hw/rtl/rfbc_vbuf.sv @@
module rfbc_vbuf #(
  parameter int unsigned DEPTH = 32,
  parameter int unsigned AW    = 5
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [7:0]    wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [7:0]    rd_data
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ hw/rtl/rfbc_seq.sv @@
module rfbc_seq #(
  parameter int unsigned ADDRESS_BYTES = 4,
  parameter int unsigned CW            = 6,
  parameter int unsigned AW            = 5
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  accept,
  input  logic                  last,
  input  logic [CW-1:0]         count,
  input  logic                  rev,
  output logic                  busy,
  output rfbc_pkg::seq_ctrl_t   ctrl,
  output logic [AW-1:0]         rd_addr
);
  import rfbc_pkg::*;

  localparam int unsigned HDR_BYTES = ADDRESS_BYTES + 3;
  localparam int unsigned HW        = $clog2(HDR_BYTES);

  state_t        state, state_next;
  logic [HW-1:0] hcnt, hcnt_next;
  logic [CW-1:0] vidx, vidx_next;
  logic [CW-1:0] ridx;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      hcnt  <= '0;
      vidx  <= '0;
    end else begin
      state <= state_next;
      hcnt  <= hcnt_next;
      vidx  <= vidx_next;
    end
  end

  // reversed order for integer values
  assign ridx    = rev ? (count - CW'(1) - vidx) : vidx;
  assign rd_addr = ridx[AW-1:0];
  assign busy    = (state != ST_IDLE);

  always_comb begin
    state_next = state;
    hcnt_next  = hcnt;
    vidx_next  = vidx;
    ctrl       = '0;
    case (state)
      ST_IDLE: begin
        if (accept && last) begin
          state_next = ST_HDR;
          hcnt_next  = '0;
        end
      end
      ST_HDR: begin
        ctrl.out_hdr = 1'b1;
        hcnt_next    = hcnt + HW'(1);
        if (hcnt == HW'(HDR_BYTES - 1)) begin
          vidx_next  = '0;
          state_next = (count == '0) ? ST_SUM : ST_RD;
        end
      end
      ST_RD: begin
        ctrl.rd_en = 1'b1;
        state_next = ST_VAL;
      end
      ST_VAL: begin
        ctrl.out_val = 1'b1;
        vidx_next    = vidx + CW'(1);
        state_next   = (vidx == count - CW'(1)) ? ST_SUM : ST_RD;
      end
      ST_SUM: begin
        ctrl.out_sum = 1'b1;
        state_next   = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

@@ hw/rtl/radio_frame_build_checksum.sv @@
// Frame builder. Take one word per start/!busy handshake; each carries at most
// one value byte, and the first word of a packet also latches address, function,
// register id and the integer flag. A word without value_last leaves busy low.
// A word with value_last starts emission: the block then holds busy high while
// it puts out ADDRESS_BYTES + 3 header bytes one per cycle, each value byte by
// a buffer read and then an output, and the checksum byte with frame_last.
// The sequencer does not overlap the registered read of the value buffer with
// output, and the checksum is kept by a one byte adder.
// Each frame byte sits on result for exactly one cycle with valid high; the
// receiver must take it then. Bytes past MAX_VALUE_LEN are dropped.
module radio_frame_build_checksum #(
  parameter int unsigned ADDRESS_BYTES = rfbc_pkg::ADDRESS_BYTES_DEF,
  parameter int unsigned MAX_VALUE_LEN = rfbc_pkg::MAX_VALUE_LEN_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  rfbc_pkg::in_t item,
  output logic          busy,
  output logic          valid,
  output rfbc_pkg::out_t result
);
  import rfbc_pkg::*;

  localparam int unsigned AW   = (MAX_VALUE_LEN > 1) ? $clog2(MAX_VALUE_LEN) : 1;
  localparam int unsigned CW   = $clog2(MAX_VALUE_LEN + 1);
  localparam int unsigned ABW  = ADDRESS_BYTES * 8;
  localparam int unsigned HDRW = ABW + 24;

  logic            accept;
  logic            in_packet;
  logic [CW-1:0]   count;
  logic [CW-1:0]   eff_count;
  logic            wr_en;
  logic [7:0]      nonce;
  logic            rev;
  logic [HDRW-1:0] hdr;
  logic [ABW+31:0] addr_wide;
  logic [7:0]      sum;
  logic [7:0]      byte_sel;
  logic [7:0]      rd_data;
  logic [AW-1:0]   rd_addr;
  seq_ctrl_t       ctrl;

  assign accept    = start && !busy;
  assign eff_count = in_packet ? count : '0;
  assign wr_en     = accept && item.has_byte && (eff_count < CW'(MAX_VALUE_LEN));
  // zero-extend or truncate to ADDRESS_BYTES
  assign addr_wide = {{ABW{1'b0}}, item.dest_address};

  always_ff @(posedge clk) begin
    if (rst) begin
      in_packet <= 1'b0;
      count     <= '0;
      nonce     <= '0;
    end else if (ctrl.out_sum) begin
      in_packet <= 1'b0;
      count     <= '0;
      nonce     <= nonce + 8'd1;
    end else if (accept) begin
      in_packet <= 1'b1;
      count     <= eff_count + CW'(wr_en);
    end
  end

  // header shifter: address msb first, nonce, function, register
  always_ff @(posedge clk) begin
    if (accept && !in_packet) begin
      hdr <= {addr_wide[ABW-1:0], nonce, item.function_code, item.register_id};
      rev <= item.is_integer;
    end else if (ctrl.out_hdr) begin
      hdr <= hdr << 8;
    end
  end

  always_comb begin
    byte_sel = sum;
    if (ctrl.out_hdr) begin
      byte_sel = hdr[HDRW-1 -: 8];
    end else if (ctrl.out_val) begin
      byte_sel = rd_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sum   <= '0;
      valid <= 1'b0;
    end else begin
      valid <= ctrl.out_hdr || ctrl.out_val || ctrl.out_sum;
      if (ctrl.out_sum) begin
        sum <= '0;
      end else if (ctrl.out_hdr || ctrl.out_val) begin
        sum <= sum + byte_sel;
      end
    end
  end

  always_ff @(posedge clk) begin
    result.frame_byte <= byte_sel;
    result.frame_last <= ctrl.out_sum;
  end

  rfbc_vbuf #(
    .DEPTH (MAX_VALUE_LEN),
    .AW    (AW)
  ) u_vbuf (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (eff_count[AW-1:0]),
    .wr_data (item.value_byte),
    .rd_en   (ctrl.rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  rfbc_seq #(
    .ADDRESS_BYTES (ADDRESS_BYTES),
    .CW            (CW),
    .AW            (AW)
  ) u_seq (
    .clk     (clk),
    .rst     (rst),
    .accept  (accept),
    .last    (item.value_last),
    .count   (count),
    .rev     (rev),
    .busy    (busy),
    .ctrl    (ctrl),
    .rd_addr (rd_addr)
  );

endmodule

@@ hw/rtl/rfbc_checker.sv @@
`include "radio_frame_build_checksum_defines.svh"

module rfbc_checker (
  input logic           clk,
  input logic           rst,
  input logic           start,
  input rfbc_pkg::in_t  item,
  input logic           busy,
  input logic           valid,
  input rfbc_pkg::out_t result
);
  import rfbc_pkg::*;

  // checksum word closes the frame and frees the block
  `RFBC_ASSERT_NOW(a_last_frees, valid && result.frame_last, !busy)
  // frame words only come out during emission
  `RFBC_ASSERT_NOW(a_valid_in_frame, valid, busy || result.frame_last)
  // a middle word is absorbed silently
  `RFBC_ASSERT_NEXT(a_mid_silent, start && !busy && !item.value_last, !busy && !valid)
  // a last word starts emission
  `RFBC_ASSERT_NEXT(a_last_starts, start && !busy && item.value_last, busy && !valid)

endmodule

bind radio_frame_build_checksum rfbc_checker u_rfbc_checker (.*);

@@ dv/radio_frame_build_checksum_tb.sv @@
`timescale 1ns / 100ps

module radio_frame_build_checksum_tb;
  import rfbc_pkg::*;

  localparam int unsigned ADDR_BYTES  = ADDRESS_BYTES_DEF;
  localparam int unsigned VALUE_DEPTH = MAX_VALUE_LEN_DEF;
  localparam int          NO_SUM      = -1;

  typedef struct {
    in_t w;
    int  sum_lit;  // known checksum of the frame this word closes, or NO_SUM
  } step_t;

  logic clk;
  logic rst;
  logic start;
  in_t  item;
  logic busy;
  logic valid;
  out_t result;

  radio_frame_build_checksum #(
    .ADDRESS_BYTES(ADDR_BYTES),
    .MAX_VALUE_LEN(VALUE_DEPTH)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .start(start),
    .item(item),
    .busy(busy),
    .valid(valid),
    .result(result)
  );

  // predictor state
  logic [7:0]  held_value [VALUE_DEPTH];
  int          held_count;
  logic [7:0]  nonce;
  bit          open_packet;
  bit          dropped;
  logic [31:0] hdr_addr;
  logic [7:0]  hdr_func;
  logic [7:0]  hdr_reg;
  logic        hdr_int;

  out_t wire_bytes_due[$];

  int errors;
  int words_sent;
  int frames_built;
  int full_frames;
  int empty_frames;
  int bytes_checked;
  bit steady;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("timeout, %0d bytes still due", wire_bytes_due.size());
    $display("CHECK FAILED");
    $finish;
  end

  function automatic void flag_error(string what);
    errors++;
    if (errors <= 10) $display("%0t: %s", $realtime, what);
  endfunction

  function automatic void emit_byte(ref logic [7:0] sum, input logic [7:0] b,
                                    input logic last);
    out_t o;
    o.frame_byte = b;
    o.frame_last = last;
    wire_bytes_due.push_back(o);
    sum = sum + b;
  endfunction

  // update the predictor with one accepted word; queue the frame it closes
  function automatic void predict_frame_word(in_t w);
    logic [7:0] sum;
    int unsigned sh;
    int k;
    if (!open_packet) begin
      hdr_addr    = w.dest_address;
      hdr_func    = w.function_code;
      hdr_reg     = w.register_id;
      hdr_int     = w.is_integer;
      held_count  = 0;
      dropped     = 1'b0;
      open_packet = 1'b1;
    end
    if (w.has_byte) begin
      if (held_count < VALUE_DEPTH) begin
        held_value[held_count] = w.value_byte;
        held_count++;
      end else begin
        dropped = 1'b1;
      end
    end
    if (!w.value_last) return;

    sum = 8'h00;
    for (k = 0; k < ADDR_BYTES; k++) begin
      sh = (ADDR_BYTES - 1 - k) * 8;
      emit_byte(sum, (sh < 32) ? 8'(hdr_addr >> sh) : 8'h00, 1'b0);
    end
    emit_byte(sum, nonce, 1'b0);
    emit_byte(sum, hdr_func, 1'b0);
    emit_byte(sum, hdr_reg, 1'b0);
    for (k = 0; k < held_count; k++)
      emit_byte(sum, held_value[hdr_int ? held_count - 1 - k : k], 1'b0);
    emit_byte(sum, sum, 1'b1);

    frames_built++;
    if (dropped) full_frames++;
    if (held_count == 0) empty_frames++;
    nonce       = nonce + 8'h01;
    open_packet = 1'b0;
    held_count  = 0;
  endfunction

  function automatic int unsigned gap_len();
    int unsigned r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  // called at a rising edge; returns at the edge that takes the word
  task automatic send_word(input in_t w);
    int unsigned idle;
    idle = gap_len();
    if (idle != 0) begin
      start <= 1'b0;
      repeat (idle) @(posedge clk);
    end
    start <= 1'b1;
    item  <= w;
    do @(posedge clk); while (busy);
    words_sent++;
    predict_frame_word(w);
  endtask

  // header fields change on every word; only the first word's should stick
  task automatic send_packet(input int len, input bit all_bytes, input int hb_pct);
    in_t w;
    int k;
    for (k = 0; k < len; k++) begin
      w.dest_address  = $urandom();
      w.function_code = 8'($urandom());
      w.register_id   = 8'($urandom());
      w.is_integer    = 1'($urandom());
      w.has_byte      = all_bytes ? 1'b1 : ($urandom_range(0, 99) < hb_pct);
      w.value_byte    = 8'($urandom());
      w.value_last    = (k == len - 1);
      send_word(w);
    end
  endtask

  function automatic step_t mk(logic [31:0] a, logic [7:0] f, logic [7:0] r, logic i,
                               logic h, logic [7:0] v, logic l, int s);
    step_t t;
    t.w = '{dest_address: a, function_code: f, register_id: r, is_integer: i,
            has_byte: h, value_byte: v, value_last: l};
    t.sum_lit = s;
    return t;
  endfunction

  always @(posedge clk) begin : frame_check
    out_t want;
    if (!rst && valid) begin
      if (wire_bytes_due.size() == 0) begin
        flag_error($sformatf("unexpected byte %02h last %0b",
                             result.frame_byte, result.frame_last));
      end else begin
        want = wire_bytes_due.pop_front();
        bytes_checked++;
        if (result.frame_byte !== want.frame_byte)
          flag_error($sformatf("frame_byte: expected %02h, got %02h",
                               want.frame_byte, result.frame_byte));
        if (result.frame_last !== want.frame_last)
          flag_error($sformatf("frame_last on byte %02h: expected %0b, got %0b",
                               want.frame_byte, want.frame_last, result.frame_last));
      end
    end
  end

  initial begin
    step_t script[$];
    int n;
    int r;
    int len;

    errors        = 0;
    words_sent    = 0;
    frames_built  = 0;
    full_frames   = 0;
    empty_frames  = 0;
    bytes_checked = 0;
    steady        = 1'b0;
    nonce         = 8'h00;
    open_packet   = 1'b0;
    held_count    = 0;
    dropped       = 1'b0;
    hdr_addr      = '0;
    hdr_func      = '0;
    hdr_reg       = '0;
    hdr_int       = 1'b0;

    rst   <= 1'b1;
    start <= 1'b0;
    item  <= '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    script = '{
      // header only frame right after reset, nonce 0
      mk(32'h01020304, 8'h10, 8'h20, 1'b0, 1'b0, 8'h00, 1'b1, 'h3A),
      mk(32'hFFFFFFFF, 8'hFF, 8'hFF, 1'b1, 1'b1, 8'hFF, 1'b1, 'hFA),
      mk(32'h00000000, 8'h00, 8'h00, 1'b0, 1'b1, 8'h00, 1'b1, 'h02),
      // integer value, bytes go out reversed; later headers ignored
      mk(32'h89ABCDEF, 8'h03, 8'h7E, 1'b1, 1'b1, 8'h11, 1'b0, NO_SUM),
      mk(32'h76543210, 8'hFC, 8'h81, 1'b0, 1'b1, 8'h22, 1'b0, NO_SUM),
      mk(32'hFFFFFFFF, 8'h00, 8'hFF, 1'b0, 1'b1, 8'h33, 1'b0, NO_SUM),
      mk(32'h00000000, 8'hFF, 8'h00, 1'b1, 1'b1, 8'h44, 1'b1, NO_SUM),
      // plain value with words that carry no byte, last one empty
      mk(32'hA5A5A55A, 8'h5A, 8'hA5, 1'b0, 1'b1, 8'hAA, 1'b0, NO_SUM),
      mk(32'h5A5A5AA5, 8'hA5, 8'h5A, 1'b1, 1'b0, 8'hFF, 1'b0, NO_SUM),
      mk(32'h5A5A5AA5, 8'hA5, 8'h5A, 1'b1, 1'b1, 8'h55, 1'b0, NO_SUM),
      mk(32'h5A5A5AA5, 8'hA5, 8'h5A, 1'b1, 1'b0, 8'h01, 1'b1, NO_SUM),
      // empty value spread over two words, integer flag set
      mk(32'h80000001, 8'h80, 8'h01, 1'b1, 1'b0, 8'h00, 1'b0, NO_SUM),
      mk(32'h7FFFFFFE, 8'h7F, 8'hFE, 1'b0, 1'b0, 8'hFF, 1'b1, NO_SUM),
      mk(32'h00000001, 8'h01, 8'h80, 1'b1, 1'b1, 8'h80, 1'b1, NO_SUM)
    };

    foreach (script[i]) begin
      send_word(script[i].w);
      if (script[i].sum_lit != NO_SUM) begin
        n = wire_bytes_due.size();
        wire_bytes_due[n - 1].frame_byte = script[i].sum_lit[7:0];
      end
    end

    // buffer overflow: extra bytes dropped, once back to back and once with gaps
    steady = 1'b1;
    send_packet(VALUE_DEPTH + 4, 1'b1, 100);
    steady = 1'b0;
    send_packet(VALUE_DEPTH + 2, 1'b1, 100);

    while (words_sent < 360) begin
      steady = ($urandom_range(0, 4) == 0);
      r = $urandom_range(0, 99);
      if (r < 40)      len = 1;
      else if (r < 78) len = $urandom_range(2, 6);
      else if (r < 93) len = $urandom_range(7, VALUE_DEPTH - 1);
      else             len = $urandom_range(VALUE_DEPTH, VALUE_DEPTH + 8);
      // a share of packets with sparse bytes, often empty when short
      if ($urandom_range(0, 9) == 0) send_packet(len, 1'b0, 30);
      else                           send_packet(len, 1'b0, 92);
    end
    start <= 1'b0;

    while (wire_bytes_due.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("%0d words in, %0d frames (%0d overflowed, %0d empty), %0d bytes compared",
             words_sent, frames_built, full_frames, empty_frames, bytes_checked);
    if (errors > 10) $display("%0d mismatches in all", errors);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
